FILE: rtl/core/ipv4lpr_pkg.sv
// ----------------------------------------------------------------------------
// IPv4 longest-prefix router package
// Shared sizes, codes, the route entry layout and the prefix mask helper.
// ----------------------------------------------------------------------------
package ipv4lpr_pkg;

    // Table capacity and the widths that follow from it.
    localparam int MAX_ROUTES   = 64;
    localparam int ROUTE_ADDR_W = (MAX_ROUTES > 1) ? $clog2(MAX_ROUTES) : 1;
    localparam int COUNT_W      = $clog2(MAX_ROUTES + 1);

    localparam logic [COUNT_W-1:0] ROUTES_FULL = COUNT_W'(MAX_ROUTES);

    // Longest legal prefix length.
    localparam logic [5:0] PREFIX_MAX = 6'd32;

    // Item kinds.
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_ROUTE = 1'b1;

    // Result status codes.
    localparam logic [2:0] STATUS_FORWARDED   = 3'd0;
    localparam logic [2:0] STATUS_NO_ROUTE    = 3'd1;
    localparam logic [2:0] STATUS_TTL_EXPIRED = 3'd2;
    localparam logic [2:0] STATUS_ADDED       = 3'd3;
    localparam logic [2:0] STATUS_FULL        = 3'd4;

    // One stored route, as held in the table memory.
    typedef struct packed {
        logic [31:0] prefix;
        logic [5:0]  length;
        logic        hop_valid;
        logic [31:0] hop;
        logic [3:0]  port;
    } route_entry_t;

    localparam int ENTRY_W = $bits(route_entry_t);

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } lpr_state_t;

    // Mask with the top len bits set; len is at most 32.
    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

FILE: rtl/core/ipv4lpr_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ipv4lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/ipv4_longest_prefix_router_top.sv
// ----------------------------------------------------------------------------
// IPv4 longest-prefix router
// Route table with add and longest-prefix-match lookup over one table memory.
// ----------------------------------------------------------------------------
// A transaction is accepted on a rising edge with start high and busy low.
// Every transaction gives exactly one result, shown on the result ports for
// one cycle with done high; the receiver cannot hold it off, so it must take
// the result in that cycle. An add leaves busy low, so the next transaction
// may follow at once. A lookup reads the stored routes one per cycle through
// the single read port of the table memory; with an empty table the no-route
// result comes without a scan. busy is high for the whole scan. The table
// needs no clearing after reset: only entries below the route count are ever
// read.
// ----------------------------------------------------------------------------
module ipv4_longest_prefix_router_top
    import ipv4lpr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        func,
    input  logic [31:0] net_prefix,
    input  logic [5:0]  prefix_bits,
    input  logic        hop_present,
    input  logic [31:0] hop_address,
    input  logic [3:0]  interface_index,
    input  logic [31:0] dest_address,
    input  logic [7:0]  ttl_in,
    output logic        done,
    output logic [2:0]  status,
    output logic [3:0]  out_interface,
    output logic [31:0] next_hop_out,
    output logic [7:0]  ttl_out
);

    // Control state.
    lpr_state_t              state_reg, state_next;
    logic [COUNT_W-1:0]      route_count_reg, route_count_next;
    logic [ROUTE_ADDR_W-1:0] scan_idx_reg, scan_idx_next;
    logic                    issue_active_reg, issue_active_next;
    logic                    eval_valid_reg, eval_valid_next;
    logic                    eval_last_reg, eval_last_next;
    logic                    found_reg, found_next;
    logic                    done_reg, done_next;

    // Payload state.
    logic [31:0]  dest_reg, dest_next;
    logic [7:0]   ttl_reg, ttl_next;
    route_entry_t best_reg, best_next;
    logic [2:0]   status_reg, status_next;
    logic [3:0]   iface_reg, iface_next;
    logic [31:0]  hop_reg, hop_next;
    logic [7:0]   ttl_out_reg, ttl_out_next;

    // Memory ports.
    logic                    ram_we;
    logic [ROUTE_ADDR_W-1:0] ram_waddr;
    route_entry_t            ram_wentry;
    logic                    ram_re;
    logic [ENTRY_W-1:0]      ram_rdata;

    logic         accept;
    logic         table_full;
    logic         issue_last;
    route_entry_t rd_entry;
    logic         hit;
    logic         better;
    logic         final_found;
    route_entry_t final_entry;

    assign accept     = start && !busy;
    assign busy       = (state_reg != S_IDLE);
    assign table_full = (route_count_reg == ROUTES_FULL);
    assign rd_entry   = route_entry_t'(ram_rdata);

    // The entry being issued is the last stored route.
    assign issue_last = ((COUNT_W'(scan_idx_reg) + COUNT_W'(1)) == route_count_reg);

    // Match test of the entry just read against the destination.
    assign hit    = (((dest_reg ^ rd_entry.prefix) & prefix_mask(rd_entry.length)) == 32'd0);
    assign better = hit && (!found_reg || (rd_entry.length > best_reg.length));

    assign final_found = found_reg || hit;
    assign final_entry = better ? rd_entry : best_reg;

    // Table write on an accepted add with room left, and the read enable during a scan.
    always_comb
    begin
        ram_we               = accept && (func == FUNC_ADD) && !table_full;
        ram_waddr            = route_count_reg[ROUTE_ADDR_W-1:0];
        ram_wentry.prefix    = net_prefix;
        ram_wentry.length    = (prefix_bits > PREFIX_MAX) ? PREFIX_MAX : prefix_bits;
        ram_wentry.hop_valid = hop_present;
        ram_wentry.hop       = hop_present ? hop_address : 32'd0;
        ram_wentry.port      = interface_index;
        ram_re               = (state_reg == S_SCAN) && issue_active_reg;
    end

    ipv4lpr_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ROUTES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wentry),
        .re   (ram_re),
        .raddr(scan_idx_reg),
        .rdata(ram_rdata)
    );

    // Next state and result logic.
    always_comb
    begin
        state_next        = state_reg;
        route_count_next  = route_count_reg;
        scan_idx_next     = scan_idx_reg;
        issue_active_next = issue_active_reg;
        eval_valid_next   = 1'b0;
        eval_last_next    = 1'b0;
        found_next        = found_reg;
        done_next         = 1'b0;
        dest_next         = dest_reg;
        ttl_next          = ttl_reg;
        best_next         = best_reg;
        status_next       = status_reg;
        iface_next        = iface_reg;
        hop_next          = hop_reg;
        ttl_out_next      = ttl_out_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    iface_next   = 4'd0;
                    hop_next     = 32'd0;
                    ttl_out_next = 8'd0;
                    if (func == FUNC_ADD)
                    begin
                        done_next = 1'b1;
                        if (table_full)
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            status_next      = STATUS_ADDED;
                            route_count_next = route_count_reg + COUNT_W'(1);
                        end
                    end
                    else if (route_count_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STATUS_NO_ROUTE;
                    end
                    else
                    begin
                        state_next        = S_SCAN;
                        dest_next         = dest_address;
                        ttl_next          = ttl_in;
                        scan_idx_next     = '0;
                        issue_active_next = 1'b1;
                        found_next        = 1'b0;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read.
                if (issue_active_reg)
                begin
                    eval_valid_next   = 1'b1;
                    eval_last_next    = issue_last;
                    issue_active_next = !issue_last;
                    scan_idx_next     = scan_idx_reg + ROUTE_ADDR_W'(1);
                end

                // Fold in the entry read last cycle.
                if (eval_valid_reg)
                begin
                    if (better)
                    begin
                        best_next  = rd_entry;
                        found_next = 1'b1;
                    end
                    if (eval_last_reg)
                    begin
                        state_next = S_IDLE;
                        done_next  = 1'b1;
                        if (!final_found)
                        begin
                            status_next = STATUS_NO_ROUTE;
                        end
                        else if (ttl_reg <= 8'd1)
                        begin
                            status_next = STATUS_TTL_EXPIRED;
                        end
                        else
                        begin
                            status_next  = STATUS_FORWARDED;
                            iface_next   = final_entry.port;
                            hop_next     = final_entry.hop_valid ? final_entry.hop : dest_reg;
                            ttl_out_next = ttl_reg - 8'd1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            route_count_reg  <= '0;
            scan_idx_reg     <= '0;
            issue_active_reg <= 1'b0;
            eval_valid_reg   <= 1'b0;
            eval_last_reg    <= 1'b0;
            found_reg        <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            route_count_reg  <= route_count_next;
            scan_idx_reg     <= scan_idx_next;
            issue_active_reg <= issue_active_next;
            eval_valid_reg   <= eval_valid_next;
            eval_last_reg    <= eval_last_next;
            found_reg        <= found_next;
            done_reg         <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        dest_reg    <= dest_next;
        ttl_reg     <= ttl_next;
        best_reg    <= best_next;
        status_reg  <= status_next;
        iface_reg   <= iface_next;
        hop_reg     <= hop_next;
        ttl_out_reg <= ttl_out_next;
    end

    assign done          = done_reg;
    assign status        = status_reg;
    assign out_interface = iface_reg;
    assign next_hop_out  = hop_reg;
    assign ttl_out       = ttl_out_reg;

    // The route count never passes the table capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        route_count_reg <= ROUTES_FULL)
        else $error("route count beyond table capacity");

    // The table is written only between lookups.
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("table write during a scan");

    // A refused add leaves the route count unchanged.
    a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_ADD) && table_full)
        |=> (route_count_reg == $past(route_count_reg)))
        else $error("refused add changed the route count");

    // An added route shows up as a count increment with its result.
    a_added_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STATUS_ADDED))
        |-> (route_count_reg == ($past(route_count_reg) + COUNT_W'(1))))
        else $error("added status without count increment");

    // Read data is evaluated only inside a scan.
    a_eval_scan: assert property (@(posedge clk) disable iff (!rst_n)
        eval_valid_reg |-> (state_reg == S_SCAN))
        else $error("entry evaluation outside a scan");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv4 longest-prefix router testbench
// Sends add and lookup transactions in random bursts, predicts every verdict
// from a shadow copy of the route table and checks each result field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import ipv4lpr_pkg::*;

    localparam int RANDOM_ITEMS = 1830;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 80;

    // One input transaction and one result, at the port widths.
    typedef struct packed {
        logic        func;
        logic [31:0] net_prefix;
        logic [5:0]  prefix_bits;
        logic        hop_present;
        logic [31:0] hop_address;
        logic [3:0]  interface_index;
        logic [31:0] dest_address;
        logic [7:0]  ttl_in;
    } route_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  out_interface;
        logic [31:0] next_hop_out;
        logic [7:0]  ttl_out;
    } verdict_t;

    logic        clk;
    logic        rst_n           = 1'b0;
    logic        start           = 1'b0;
    logic        func            = FUNC_ADD;
    logic [31:0] net_prefix      = '0;
    logic [5:0]  prefix_bits     = '0;
    logic        hop_present     = 1'b0;
    logic [31:0] hop_address     = '0;
    logic [3:0]  interface_index = '0;
    logic [31:0] dest_address    = '0;
    logic [7:0]  ttl_in          = '0;
    logic        busy;
    logic        done;
    logic [2:0]  status;
    logic [3:0]  out_interface;
    logic [31:0] next_hop_out;
    logic [7:0]  ttl_out;

    route_req_t pending_requests[$];
    verdict_t   expected_verdicts[$];
    int         mismatch_count = 0;

    // Shadow route table used for prediction.
    logic [31:0] shadow_prefix[MAX_ROUTES];
    int          shadow_len[MAX_ROUTES];
    logic        shadow_hop_valid[MAX_ROUTES];
    logic [31:0] shadow_hop[MAX_ROUTES];
    logic [3:0]  shadow_port[MAX_ROUTES];
    int          shadow_count = 0;

    // Routes the stimulus generator knows to be stored, for aiming lookups.
    logic [31:0] planned_prefix[$];
    int          planned_len[$];

    ipv4_longest_prefix_router_top dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .func            (func),
        .net_prefix      (net_prefix),
        .prefix_bits     (prefix_bits),
        .hop_present     (hop_present),
        .hop_address     (hop_address),
        .interface_index (interface_index),
        .dest_address    (dest_address),
        .ttl_in          (ttl_in),
        .done            (done),
        .status          (status),
        .out_interface   (out_interface),
        .next_hop_out    (next_hop_out),
        .ttl_out         (ttl_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Mask with the top len bits set, len already limited to 32.
    function automatic logic [31:0] route_mask(input int len);
        route_mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
    endfunction

    function automatic int clamp_len(input int len);
        clamp_len = (len > 32) ? 32 : len;
    endfunction

    // Applies one transaction to the shadow table and returns its verdict.
    function automatic verdict_t route_table_predict(input route_req_t req);
        verdict_t v;
        int       best;
        v    = '0;
        best = -1;
        if (req.func == FUNC_ADD)
        begin
            if (shadow_count >= MAX_ROUTES)
                v.status = STATUS_FULL;
            else
            begin
                shadow_prefix[shadow_count]    = req.net_prefix;
                shadow_len[shadow_count]       = clamp_len(int'(req.prefix_bits));
                shadow_hop_valid[shadow_count] = req.hop_present;
                shadow_hop[shadow_count]       = req.hop_present ? req.hop_address : 32'h0;
                shadow_port[shadow_count]      = req.interface_index;
                shadow_count++;
                v.status = STATUS_ADDED;
            end
        end
        else
        begin
            // Strictly longer wins, so the earlier route keeps a tie.
            for (int i = 0; i < shadow_count; i++)
            begin
                if (((req.dest_address ^ shadow_prefix[i]) & route_mask(shadow_len[i])) == 0
                    && (best < 0 || shadow_len[i] > shadow_len[best]))
                    best = i;
            end
            if (best < 0)
                v.status = STATUS_NO_ROUTE;
            else if (req.ttl_in <= 8'd1)
                v.status = STATUS_TTL_EXPIRED;
            else
            begin
                v.status        = STATUS_FORWARDED;
                v.out_interface = shadow_port[best];
                v.next_hop_out  = shadow_hop_valid[best] ? shadow_hop[best] : req.dest_address;
                v.ttl_out       = req.ttl_in - 8'd1;
            end
        end
        return v;
    endfunction

    // Queues an add; the lookup fields carry random noise.
    task automatic queue_add(input logic [31:0] pfx, input int len, input logic hp,
                             input logic [31:0] hop, input logic [3:0] iface);
        route_req_t req;
        req.func            = FUNC_ADD;
        req.net_prefix      = pfx;
        req.prefix_bits     = 6'(len);
        req.hop_present     = hp;
        req.hop_address     = hop;
        req.interface_index = iface;
        req.dest_address    = $urandom;
        req.ttl_in          = 8'($urandom);
        pending_requests.insert(pending_requests.size(), req);
        if (planned_prefix.size() < MAX_ROUTES)
        begin
            planned_prefix.insert(planned_prefix.size(), pfx);
            planned_len.insert(planned_len.size(), clamp_len(len));
        end
    endtask

    // Queues a lookup; the add fields carry random noise.
    task automatic queue_lookup(input logic [31:0] dst, input logic [7:0] ttl);
        route_req_t req;
        req.func            = FUNC_ROUTE;
        req.net_prefix      = $urandom;
        req.prefix_bits     = 6'($urandom);
        req.hop_present     = 1'($urandom);
        req.hop_address     = $urandom;
        req.interface_index = 4'($urandom);
        req.dest_address    = dst;
        req.ttl_in          = ttl;
        pending_requests.insert(pending_requests.size(), req);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Stimulus: directed table build and lookups, then random traffic.
    initial
    begin : stimulus
        logic [31:0] pfx;
        logic [31:0] dst;
        logic [31:0] keep;
        logic [7:0]  ttl;
        int          len;
        int          pick;

        // Lookups on an empty table; no route is reported ahead of the TTL.
        queue_lookup(32'h0000_0000, 8'd0);
        queue_lookup(32'hFFFF_FFFF, 8'd255);

        // Direct route with a stray hop address, then two equal /24 routes.
        queue_add(32'hC0A8_0000, 16, 1'b0, 32'hDEAD_BEEF, 4'd15);
        queue_add(32'hC0A8_0100, 24, 1'b1, 32'hFFFF_FFFF, 4'd7);
        queue_add(32'hC0A8_0100, 24, 1'b1, 32'h0A00_0001, 4'd1);
        // Host route, over-long length that saturates, and a /1 route.
        queue_add(32'hFFFF_FFFF, 32, 1'b1, 32'h0000_0000, 4'd0);
        queue_add(32'h0000_0000, 63, 1'b0, 32'h1234_5678, 4'd9);
        queue_add(32'h8000_0000, 1, 1'b1, 32'h0102_0304, 4'd4);

        queue_lookup(32'hC0A8_0105, 8'd255);
        queue_lookup(32'hC0A8_FF01, 8'd2);
        queue_lookup(32'hC0A8_0105, 8'd1);
        queue_lookup(32'hC0A8_0105, 8'd0);
        queue_lookup(32'hFFFF_FFFF, 8'd128);
        queue_lookup(32'h0000_0000, 8'd64);
        queue_lookup(32'h0000_0001, 8'd64);
        queue_lookup(32'h8000_0001, 8'd3);
        queue_lookup(32'h7FFF_FFFF, 8'd200);

        // Random traffic: mostly lookups aimed at stored prefixes. The last
        // free slot gets a default route, and later adds hit a full table.
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if ($urandom_range(0, 99) < 12)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63)
                                                  : $urandom_range(1, 32);
                pfx  = $urandom;
                pick = $urandom_range(0, 9);
                if (planned_prefix.size() != 0 && pick < 5)
                begin
                    pick = $urandom_range(0, planned_prefix.size() - 1);
                    keep = route_mask(planned_len[pick]);
                    if ($urandom_range(0, 4) == 0)
                    begin
                        // Same prefix and length as an earlier route.
                        pfx = planned_prefix[pick];
                        len = planned_len[pick];
                    end
                    else
                        pfx = (planned_prefix[pick] & keep) | (pfx & ~keep);
                end
                if (planned_prefix.size() == MAX_ROUTES - 1)
                    len = 0;
                queue_add(pfx, len, 1'($urandom), $urandom, 4'($urandom));
            end
            else
            begin
                dst = $urandom;
                if (planned_prefix.size() != 0 && $urandom_range(0, 99) < 65)
                begin
                    pick = $urandom_range(0, planned_prefix.size() - 1);
                    keep = route_mask(planned_len[pick]);
                    dst  = (planned_prefix[pick] & keep) | (dst & ~keep);
                end
                case ($urandom_range(0, 7))
                    0: ttl = 8'd0;
                    1: ttl = 8'd1;
                    2: ttl = 8'd2;
                    3: ttl = 8'd255;
                    default: ttl = 8'($urandom);
                endcase
                queue_lookup(dst, ttl);
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Drain: everything sent and every verdict returned.
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || start || expected_verdicts.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && expected_verdicts.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Driver: bursts of back-to-back transactions separated by random gaps.
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge clk)
    begin : driver
        route_req_t req;
        route_req_t taken;
        logic       load_next;
        load_next = 1'b0;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                // The transaction on the ports was just accepted.
                taken = {func, net_prefix, prefix_bits, hop_present, hop_address,
                         interface_index, dest_address, ttl_in};
                expected_verdicts.insert(expected_verdicts.size(),
                                         route_table_predict(taken));
                if (burst_left > 1 && pending_requests.size() != 0)
                begin
                    burst_left <= burst_left - 1;
                    load_next = 1'b1;
                end
                else
                begin
                    start    <= 1'b0;
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else if (!start)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else if (pending_requests.size() != 0)
                begin
                    burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                              : $urandom_range(1, 8);
                    load_next = 1'b1;
                end
            end
            if (load_next)
            begin
                req = pending_requests.pop_front();
                start           <= 1'b1;
                func            <= req.func;
                net_prefix      <= req.net_prefix;
                prefix_bits     <= req.prefix_bits;
                hop_present     <= req.hop_present;
                hop_address     <= req.hop_address;
                interface_index <= req.interface_index;
                dest_address    <= req.dest_address;
                ttl_in          <= req.ttl_in;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest verdict.
    always @(posedge clk)
    begin : monitor
        verdict_t want;
        if (rst_n && done)
        begin
            if (expected_verdicts.size() == 0)
                report_mismatch($sformatf("unexpected result, status %0d", status));
            else
            begin
                want = expected_verdicts.pop_front();
                if (status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              status, want.status));
                if (out_interface !== want.out_interface)
                    report_mismatch($sformatf("out_interface %0d, expected %0d",
                                              out_interface, want.out_interface));
                if (next_hop_out !== want.next_hop_out)
                    report_mismatch($sformatf("next_hop_out %h, expected %h",
                                              next_hop_out, want.next_hop_out));
                if (ttl_out !== want.ttl_out)
                    report_mismatch($sformatf("ttl_out %0d, expected %0d",
                                              ttl_out, want.ttl_out));
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    int idle_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

FILE: files.f
rtl/core/ipv4lpr_pkg.sv
rtl/core/ipv4lpr_ram.sv
rtl/core/ipv4_longest_prefix_router_top.sv
tb/tb_top.sv
